### rtl/lmc_pkg.sv
`default_nettype none

package lmc_pkg;

    // default sizes of the frame store and the element
    localparam int MAX_COLUMNS_DEF   = 1024;
    localparam int MAX_ROWS_DEF      = 1024;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CFG_WIDTH   = 11;
    localparam int TOTAL_WIDTH = 19;
    localparam int FOUND_WIDTH = 3;

    // position of the element being taken in, as seen by the decision logic
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic row_last;
        logic col_last;
    } lmc_pos_t;

    // decision for one element, registered in the cycle after its transaction
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [FOUND_WIDTH-1:0] found;
    } lmc_res_t;

endpackage

`default_nettype wire

### rtl/lmc_ram.sv
`default_nettype none

module lmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/lmc_window.sv
`default_nettype none

module lmc_window
    import lmc_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            take,
    input  wire logic signed [ELEMENT_WIDTH-1:0] element,
    input  wire logic signed [ELEMENT_WIDTH-1:0] upper,
    input  wire logic signed [ELEMENT_WIDTH-1:0] middle,
    input  wire lmc_pos_t                        pos,
    output lmc_res_t                             res
);

    logic signed [ELEMENT_WIDTH-1:0] win_reg [3][3];
    lmc_pos_t                        pos_reg;
    logic                            valid_reg;
    logic                            hit_a;
    logic                            hit_b;
    logic                            hit_c;
    logic                            hit_d;

    // centre below every neighbour on the sides that exist
    function automatic logic is_min(input int cr, input int cc, input logic top,
                                    input logic left, input logic right,
                                    input logic bottom);
        logic ok;
        int   r;
        int   k;
        ok = 1'b1;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                r = cr + dr;
                k = cc + dc;
                if (!(dr == 0 && dc == 0) && (dr >= 0 || top) && (dr <= 0 || bottom)
                    && (dc >= 0 || left) && (dc <= 0 || right)
                    && r >= 0 && r <= 2 && k >= 0 && k <= 2)
                begin
                    if (!(win_reg[cr[1:0]][cc[1:0]] < win_reg[r[1:0]][k[1:0]]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    // window shift and position capture on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            valid_reg <= take;
            if (take)
            begin
                pos_reg <= pos;
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= upper;
                win_reg[1][2] <= middle;
                win_reg[2][2] <= element;
            end
        end
    end

    // up to four cells become decidable with one element
    always_comb
    begin
        hit_a = pos_reg.row_ge1 && pos_reg.col_ge1
                && is_min(1, 1, pos_reg.row_ge2, pos_reg.col_ge2, 1'b1, 1'b1);
        hit_b = pos_reg.row_ge1 && pos_reg.col_last
                && is_min(1, 2, pos_reg.row_ge2, 1'b1, 1'b0, 1'b1);
        hit_c = pos_reg.row_last && pos_reg.col_ge1
                && is_min(2, 1, 1'b1, pos_reg.col_ge2, 1'b1, 1'b0);
        hit_d = pos_reg.row_last && pos_reg.col_last
                && is_min(2, 2, 1'b1, 1'b1, 1'b0, 1'b0);
        res.valid = valid_reg;
        res.last  = pos_reg.row_last && pos_reg.col_last;
        res.found = {{(FOUND_WIDTH-1){1'b0}}, hit_a} + {{(FOUND_WIDTH-1){1'b0}}, hit_b}
                  + {{(FOUND_WIDTH-1){1'b0}}, hit_c} + {{(FOUND_WIDTH-1){1'b0}}, hit_d};
    end

endmodule

`default_nettype wire

### rtl/local_minimum_counter.sv
`default_nettype none

// Counts the strict local minima (3x3 neighbourhood, border elements use only the
// neighbours they have) of a signed matrix streamed in raster order, one element per
// input transaction, and emits the count as one output transaction after the last
// element of each frame. Frame size comes from row_count (address 0) and column_count
// (address 4), 11 bits; values below 2 act as 2, values above MAX_ROWS / MAX_COLUMNS
// act as the maximum, and any write restarts the frame. One element is taken every
// clock cycle unless in_stall is set; each element goes through one window register
// stage and the count then through the result register. The previous-row data come
// from a single line RAM with a registered read addressed one column ahead. The last
// element of a frame is held off only while the previous count waits on the output.
module local_minimum_counter
    import lmc_pkg::*;
#(
    parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [ELEMENT_WIDTH-1:0] element_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [TOTAL_WIDTH-1:0]          minimum_total
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    logic [CFG_WIDTH-1:0]   row_count_reg;
    logic [CFG_WIDTH-1:0]   column_count_reg;
    logic [ROW_W-1:0]       row_last_reg;
    logic [ROW_W-1:0]       row_last_next;
    logic [COL_W-1:0]       col_last_reg;
    logic [COL_W-1:0]       col_last_next;
    logic [ROW_W-1:0]       row_pos_reg;
    logic [ROW_W-1:0]       row_pos_next;
    logic [COL_W-1:0]       col_pos_reg;
    logic [COL_W-1:0]       col_pos_next;
    logic [TOTAL_WIDTH-1:0] total_reg;
    logic [TOTAL_WIDTH-1:0] total_sum;
    logic [TOTAL_WIDTH-1:0] out_total_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   cfg_write;
    logic [31:0]            wval;
    logic                   take;
    logic                   last_pos;
    lmc_pos_t               pos;
    lmc_res_t               res;
    logic [2*ELEMENT_WIDTH-1:0] line_rd;
    logic [2*ELEMENT_WIDTH-1:0] line_wr;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign wval      = {{(32-CFG_WIDTH){1'b0}}, pwdata[CFG_WIDTH-1:0]};

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = {{(32-CFG_WIDTH){1'b0}}, row_count_reg};
            REG_COLUMN_COUNT: prdata = {{(32-CFG_WIDTH){1'b0}}, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    // clamped last index for a written size
    always_comb
    begin
        if (wval < 32'd2)
        begin
            row_last_next = ROW_W'(1);
            col_last_next = COL_W'(1);
        end
        else
        begin
            if (wval > 32'(MAX_ROWS))
            begin
                row_last_next = ROW_W'(MAX_ROWS - 1);
            end
            else
            begin
                row_last_next = ROW_W'(wval - 32'd1);
            end
            if (wval > 32'(MAX_COLUMNS))
            begin
                col_last_next = COL_W'(MAX_COLUMNS - 1);
            end
            else
            begin
                col_last_next = COL_W'(wval - 32'd1);
            end
        end
    end

    // position of the incoming element
    assign last_pos = (row_pos_reg == row_last_reg) && (col_pos_reg == col_last_reg);
    assign in_stall = last_pos && out_valid_reg;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        pos.row_ge1  = row_pos_reg != '0;
        pos.row_ge2  = row_pos_reg > ROW_W'(1);
        pos.col_ge1  = col_pos_reg != '0;
        pos.col_ge2  = col_pos_reg > COL_W'(1);
        pos.row_last = row_pos_reg == row_last_reg;
        pos.col_last = col_pos_reg == col_last_reg;
    end

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_write)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (take)
        begin
            if (col_pos_reg == col_last_reg)
            begin
                col_pos_next = '0;
                row_pos_next = (row_pos_reg == row_last_reg) ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    // line store, one entry per column holding the two rows above
    assign line_wr = {line_rd[ELEMENT_WIDTH-1:0], element_value};

    lmc_ram #(
        .WIDTH (2*ELEMENT_WIDTH),
        .DEPTH (MAX_COLUMNS)
    ) u_line_ram (
        .clk   (clk),
        .we    (take),
        .waddr (col_pos_reg),
        .wdata (line_wr),
        .raddr (col_pos_next),
        .rdata (line_rd)
    );

    // window and neighbour comparisons
    lmc_window #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .element (element_value),
        .upper   (line_rd[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]),
        .middle  (line_rd[ELEMENT_WIDTH-1:0]),
        .pos     (pos),
        .res     (res)
    );

    // running count and result register
    assign total_sum      = total_reg + {{(TOTAL_WIDTH-FOUND_WIDTH){1'b0}}, res.found};
    assign out_valid_next = (out_valid_reg && out_stall) || (res.valid && res.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_WIDTH'(2);
            column_count_reg <= CFG_WIDTH'(2);
            row_last_reg     <= ROW_W'(1);
            col_last_reg     <= COL_W'(1);
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                total_reg <= '0;
                unique case (paddr[2])
                    REG_ROW_COUNT:
                    begin
                        row_count_reg <= pwdata[CFG_WIDTH-1:0];
                        row_last_reg  <= row_last_next;
                    end
                    REG_COLUMN_COUNT:
                    begin
                        column_count_reg <= pwdata[CFG_WIDTH-1:0];
                        col_last_reg     <= col_last_next;
                    end
                    default:
                    begin
                        row_count_reg <= row_count_reg;
                    end
                endcase
            end
            else if (res.valid)
            begin
                total_reg <= res.last ? '0 : total_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res.last)
        begin
            out_total_reg <= total_sum;
        end
    end

    assign out_valid     = out_valid_reg;
    assign minimum_total = out_total_reg;

endmodule

`default_nettype wire
